// ----- sv/scrm_pkg.sv -----
// ----------------------------------------------------------------------------
// scrm_pkg
// Shared types and codes for the two-wire camera register access master.
// ----------------------------------------------------------------------------
package scrm_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [6:0] WRITE_LAST_STEP = 7'd91;
   localparam logic [6:0] READ_LAST_STEP  = 7'd119;

   localparam logic [6:0] DEVICE_ADDR_RESET = 7'h21;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'b001,
      KIND_WRITE = 3'b010,
      KIND_READ  = 3'b100
   } kind_type;

   typedef enum logic [2:0] {
      SEG_START = 3'd0,
      SEG_STOP  = 3'd1,
      SEG_IDLE  = 3'd2,
      SEG_ADDRW = 3'd3,
      SEG_ADDRR = 3'd4,
      SEG_REG   = 3'd5,
      SEG_DATA  = 3'd6,
      SEG_READ  = 3'd7
   } seg_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] step;
      logic [3:0] bit_idx;
      logic [7:0] reg_latch;
      logic [7:0] data_latch;
      logic [7:0] shift_in;
      logic       nack;
      logic       scl;
      logic       sda;
      logic       drv;
   } seq_state_type;

endpackage

// ----- sv/sccb_register_access_master_unit.sv -----
// ----------------------------------------------------------------------------
// sccb_register_access_master_unit
// Two-wire camera register master, one bus pin step per tick transfer.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result transfer. The unit takes one
// transfer per clock cycle while the result side does not stall; a result
// passes through the input register and then the result register, with the pin
// step evaluated between them. A write command then needs 92 tick transfers
// and a read command 120; a command given while busy is ignored.
module sccb_register_access_master_unit
   import scrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // reg_addr[7:0], write_data[15:8], sda_in[16], zero pad
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl[0], sda_level[1], sda_drive[2], busy_res[3],
                                    // done_res[4], read_data[12:5], nack[13], zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic          in_valid_ff;
   logic [1:0]    in_op_ff;
   logic [7:0]    in_reg_ff;
   logic [7:0]    in_wd_ff;
   logic          in_sda_ff;
   logic          out_valid_ff;
   logic [15:0]   out_data_ff;
   logic [15:0]   out_data_in;
   seq_state_type state_ff;
   seq_state_type state_in;
   logic          step_done;
   logic          advance;
   logic [6:0]    device_addr;

   scrm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .device_addr (device_addr)
   );

   scrm_step u_step (
      .cur         (state_ff),
      .device_addr (device_addr),
      .opcode      (in_op_ff),
      .reg_addr    (in_reg_ff),
      .write_data  (in_wd_ff),
      .sda_in      (in_sda_ff),
      .nxt         (state_in),
      .done        (step_done)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign out_data_in = {2'b00, state_in.nack, state_in.shift_in, step_done,
                         (state_in.kind != KIND_NONE), state_in.drv, state_in.sda,
                         state_in.scl};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{kind: KIND_NONE, step: 7'd0, bit_idx: 4'd0, reg_latch: 8'd0,
                           data_latch: 8'd0, shift_in: 8'd0, nack: 1'b0,
                           scl: 1'b1, sda: 1'b1, drv: 1'b1};
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= req_tuser;
         in_reg_ff <= req_tdata[7:0];
         in_wd_ff  <= req_tdata[15:8];
         in_sda_ff <= req_tdata[16];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff.kind == KIND_NONE |-> state_ff.step == 7'd0)
      else $error("step counter not cleared while idle");

   a_write_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.kind == KIND_WRITE |-> state_ff.step <= WRITE_LAST_STEP)
      else $error("write sequence ran past its last step");

   a_idle_line_driven: assert property (@(posedge clock) disable iff (reset)
      state_ff.kind == KIND_NONE |-> state_ff.drv && state_ff.scl)
      else $error("bus not parked with clock high and data driven while idle");

   a_done_clears_busy: assert property (@(posedge clock) disable iff (reset)
      advance && step_done |=> state_ff.kind == KIND_NONE)
      else $error("sequencer still busy after final step");

   a_bit_index_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_idx <= 4'd8)
      else $error("read bit index out of range");
`endif

endmodule

// ----- sv/scrm_csr.sv -----
// ----------------------------------------------------------------------------
// scrm_csr
// Configuration register block: holds the 7-bit device bus address.
// ----------------------------------------------------------------------------
module scrm_csr
   import scrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [6:0]  device_addr
);

   logic [6:0] dev_addr_ff;
   logic [6:0] dev_addr_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];

   always_comb begin
      dev_addr_in = dev_addr_ff;
      if (wr_en) begin
         dev_addr_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEVICE_ADDR_RESET;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   assign csr_prdata  = csr_paddr[2] ? 32'd0 : {25'd0, dev_addr_ff};
   assign device_addr = dev_addr_ff;

endmodule

// ----- sv/scrm_step.sv -----
// ----------------------------------------------------------------------------
// scrm_step
// One bus pin step: decodes the step counter into segment and offset and
// forms the next sequencer state.
// ----------------------------------------------------------------------------
module scrm_step
   import scrm_pkg::*;
(
   input  seq_state_type cur,
   input  logic [6:0]    device_addr,
   input  logic [1:0]    opcode,
   input  logic [7:0]    reg_addr,
   input  logic [7:0]    write_data,
   input  logic          sda_in,
   output seq_state_type nxt,
   output logic          done
);

   seg_type    seg;
   logic [6:0] base;
   logic [4:0] ofs;
   logic [7:0] seg_byte;
   logic [2:0] q;
   logic [4:0] r;
   logic       is_rd;
   logic       last;

   assign is_rd = (cur.kind == KIND_READ);

   always_comb begin
      seg  = SEG_START;
      base = 7'd0;
      if (cur.step < 7'd3) begin
         seg  = SEG_START;
         base = 7'd0;
      end else if (cur.step < 7'd31) begin
         seg  = SEG_ADDRW;
         base = 7'd3;
      end else if (cur.step < 7'd60) begin
         seg  = SEG_REG;
         base = 7'd31;
      end else if (!is_rd) begin
         if (cur.step < 7'd89) begin
            seg  = SEG_DATA;
            base = 7'd60;
         end else begin
            seg  = SEG_STOP;
            base = 7'd89;
         end
      end else if (cur.step < 7'd63) begin
         seg  = SEG_STOP;
         base = 7'd60;
      end else if (cur.step < 7'd64) begin
         seg  = SEG_IDLE;
         base = 7'd63;
      end else if (cur.step < 7'd67) begin
         seg  = SEG_START;
         base = 7'd64;
      end else if (cur.step < 7'd95) begin
         seg  = SEG_ADDRR;
         base = 7'd67;
      end else if (cur.step < 7'd117) begin
         seg  = SEG_READ;
         base = 7'd95;
      end else begin
         seg  = SEG_STOP;
         base = 7'd117;
      end
   end

   assign ofs = 5'(cur.step - base);

   always_comb begin
      q = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (ofs >= 5'(3 * k)) begin
            q = 3'(k);
         end
      end
   end

   assign r = ofs - 5'({q, 1'b0}) - 5'(q);

   always_comb begin
      unique case (seg)
         SEG_ADDRW: seg_byte = {device_addr, 1'b0};
         SEG_ADDRR: seg_byte = {device_addr, 1'b1};
         SEG_REG:   seg_byte = cur.reg_latch;
         default:   seg_byte = cur.data_latch;
      endcase
   end

   assign last = is_rd ? (cur.step == READ_LAST_STEP) : (cur.step == WRITE_LAST_STEP);

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if ((opcode == OP_WRITE || opcode == OP_READ) && cur.kind == KIND_NONE) begin
         nxt.kind       = (opcode == OP_WRITE) ? KIND_WRITE : KIND_READ;
         nxt.reg_latch  = reg_addr;
         nxt.data_latch = write_data;
         nxt.step       = 7'd0;
         nxt.bit_idx    = 4'd0;
         nxt.shift_in   = 8'd0;
         nxt.nack       = 1'b0;
      end else if (opcode == OP_TICK && cur.kind != KIND_NONE) begin
         unique case (seg)
            SEG_START: begin
               if (ofs == 5'd0) begin
                  nxt.drv = 1'b1;
                  nxt.scl = 1'b1;
               end else begin
                  nxt.sda = (ofs == 5'd1);
               end
            end
            SEG_STOP: begin
               if (ofs == 5'd0) begin
                  nxt.drv = 1'b1;
                  nxt.scl = 1'b1;
               end else begin
                  nxt.sda = (ofs != 5'd1);
               end
            end
            SEG_IDLE: begin
               nxt.scl = cur.scl;
            end
            SEG_READ: begin
               if (ofs == 5'd0) begin
                  nxt.sda = 1'b0;
               end else if (ofs <= 5'd16) begin
                  nxt.drv = 1'b0;
                  if (ofs[0]) begin
                     nxt.scl = 1'b0;
                  end else begin
                     nxt.scl = 1'b1;
                     if (sda_in && !cur.bit_idx[3]) begin
                        nxt.shift_in[~cur.bit_idx[2:0]] = 1'b1;
                     end
                     nxt.bit_idx = cur.bit_idx + 4'd1;
                  end
               end else if (ofs == 5'd17) begin
                  nxt.drv = 1'b1;
                  nxt.sda = 1'b1;
               end else if (ofs == 5'd18 || ofs == 5'd21) begin
                  nxt.scl = 1'b0;
               end else if (ofs == 5'd19) begin
                  nxt.scl = 1'b1;
               end else begin
                  nxt.sda = 1'b0;
               end
            end
            default: begin
               if (ofs < 5'd24) begin
                  if (ofs == 5'd0) begin
                     nxt.drv = 1'b1;
                  end
                  if (r == 5'd0) begin
                     nxt.scl = 1'b0;
                  end else if (r == 5'd1) begin
                     nxt.sda = seg_byte[~q];
                  end else begin
                     nxt.scl = 1'b1;
                  end
               end else if (ofs == 5'd24 || ofs == 5'd28) begin
                  nxt.scl = 1'b0;
               end else if (ofs == 5'd25) begin
                  nxt.sda = 1'b1;
               end else if (ofs == 5'd26) begin
                  nxt.drv  = 1'b0;
                  nxt.scl  = 1'b0;
                  nxt.nack = cur.nack | sda_in;
               end else begin
                  nxt.scl = 1'b1;
               end
            end
         endcase
         nxt.step = cur.step + 7'd1;
         if (last) begin
            nxt.kind = KIND_NONE;
            nxt.step = 7'd0;
            done     = 1'b1;
         end
      end
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the two-wire camera register access master. Command and
// tick transfers go in on the request stream, with random gaps on both
// streams. A local model of the bus sequence tracks the pin levels, the
// sampled byte and the acknowledge flag. Every result transfer is checked
// field by field against it, in order. Device address changes go through
// the APB port between transactions and are read back.
// ----------------------------------------------------------------------------
module testbench;
   import scrm_pkg::*;

   localparam logic [1:0] OP_UNUSED          = 2'd3;
   localparam logic [2:0] CSR_DEVICE_ADDRESS = 3'd0;
   localparam int         WRITE_TICKS        = int'(WRITE_LAST_STEP) + 1;
   localparam int         READ_TICKS         = int'(READ_LAST_STEP) + 1;
   localparam int         ITEM_TARGET        = 1100;
   localparam int         STALL_LIMIT        = 4000;

   typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_type;

   typedef struct packed {
      logic       nack;
      logic [7:0] read_data;
      logic       done;
      logic       busy;
      logic       sda_drive;
      logic       sda_level;
      logic       scl;
   } pin_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // reg_addr[7:0], write_data[15:8], sda_in[16], zero pad
   logic [1:0]  req_tuser   = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // scl[0], sda_level[1], sda_drive[2], busy_res[3],
                                    // done_res[4], read_data[12:5], nack[13], zero pad
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // bus sequence model
   kind_type    bus_kind     = KIND_NONE;
   logic [7:0]  bus_step     = '0;
   logic [3:0]  bus_bit      = '0;
   logic [7:0]  bus_reg      = '0;
   logic [7:0]  bus_data     = '0;
   logic [7:0]  bus_shift    = '0;
   logic        bus_nack     = 1'b0;
   logic        bus_scl      = 1'b1;
   logic        bus_sda      = 1'b1;
   logic        bus_drv      = 1'b1;
   logic [6:0]  bus_dev_addr = DEVICE_ADDR_RESET;

   pin_result_type expected_pins[$];
   int error_count  = 0;
   int rsp_count    = 0;
   int items_sent   = 0;
   int stall_cycles = 0;
   int sink_hold    = 0;
   bit src_idle_on  = 1'b1;
   bit sink_idle_on = 1'b1;

   sccb_register_access_master_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic seg_type plan_seg(kind_type k, int i);
      if (k == KIND_WRITE) begin
         case (i)
            0:       return SEG_START;
            1:       return SEG_ADDRW;
            2:       return SEG_REG;
            3:       return SEG_DATA;
            default: return SEG_STOP;
         endcase
      end
      case (i) inside
         0, 5:    return SEG_START;
         1:       return SEG_ADDRW;
         2:       return SEG_REG;
         3, 8:    return SEG_STOP;
         4:       return SEG_IDLE;
         6:       return SEG_ADDRR;
         default: return SEG_READ;
      endcase
   endfunction

   function automatic int seg_length(seg_type s);
      case (s) inside
         SEG_START, SEG_STOP: return 3;
         SEG_IDLE:            return 1;
         SEG_ADDRW, SEG_ADDRR: return 28;
         SEG_REG, SEG_DATA:   return 29;
         default:             return 22;
      endcase
   endfunction

   function automatic void apply_pin_step(seg_type s, int o, logic sda);
      logic [7:0] b;
      case (s)
         SEG_START: begin
            if (o == 0) begin
               bus_drv = 1'b1;
               bus_scl = 1'b1;
            end else begin
               bus_sda = (o == 1);
            end
         end
         SEG_STOP: begin
            if (o == 0) begin
               bus_drv = 1'b1;
               bus_scl = 1'b1;
            end else begin
               bus_sda = (o != 1);
            end
         end
         SEG_IDLE: ;
         SEG_READ: begin
            if (o == 0) begin
               bus_sda = 1'b0;   // data latch cleared while still released
            end else if (o <= 16) begin
               bus_drv = 1'b0;
               if (o % 2 == 1) begin
                  bus_scl = 1'b0;
               end else begin
                  bus_scl = 1'b1;
                  if (sda && bus_bit < 8) bus_shift[7 - bus_bit] = 1'b1;
                  bus_bit = bus_bit + 4'd1;
               end
            end else if (o == 17) begin
               bus_drv = 1'b1;
               bus_sda = 1'b1;
            end else if (o == 18 || o == 21) begin
               bus_scl = 1'b0;
            end else if (o == 19) begin
               bus_scl = 1'b1;
            end else begin
               bus_sda = 1'b0;
            end
         end
         default: begin
            case (s)
               SEG_ADDRW: b = {bus_dev_addr, 1'b0};
               SEG_ADDRR: b = {bus_dev_addr, 1'b1};
               SEG_REG:   b = bus_reg;
               default:   b = bus_data;
            endcase
            if (o < 24) begin
               if (o == 0) bus_drv = 1'b1;
               case (o % 3)
                  0:       bus_scl = 1'b0;
                  1:       bus_sda = b[7 - o / 3];
                  default: bus_scl = 1'b1;
               endcase
            end else if (o == 24 || o == 28) begin
               bus_scl = 1'b0;
            end else if (o == 25) begin
               bus_sda = 1'b1;
            end else if (o == 26) begin
               bus_drv = 1'b0;
               bus_scl = 1'b0;
               if (sda) bus_nack = 1'b1;
            end else begin
               bus_scl = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic pin_result_type predict_pin_step(logic [1:0] op, logic [7:0] ra,
                                                       logic [7:0] wd, logic sda);
      pin_result_type r;
      int nseg;
      int i;
      int o;
      r = '0;
      if ((op == OP_WRITE || op == OP_READ) && bus_kind == KIND_NONE) begin
         if (op == OP_WRITE) bus_kind = KIND_WRITE;
         else bus_kind = KIND_READ;
         bus_reg   = ra;
         bus_data  = wd;
         bus_step  = '0;
         bus_bit   = '0;
         bus_shift = '0;
         bus_nack  = 1'b0;
      end else if (op == OP_TICK && bus_kind != KIND_NONE) begin
         nseg = (bus_kind == KIND_READ) ? 9 : 5;
         o = int'(bus_step);
         i = 0;
         while (i < nseg && o >= seg_length(plan_seg(bus_kind, i))) begin
            o -= seg_length(plan_seg(bus_kind, i));
            i++;
         end
         if (i < nseg) apply_pin_step(plan_seg(bus_kind, i), o, sda);
         bus_step = bus_step + 8'd1;
         if (i + 1 >= nseg && o + 1 >= seg_length(plan_seg(bus_kind, nseg - 1))) begin
            bus_kind = KIND_NONE;
            bus_step = '0;
            r.done   = 1'b1;
         end
      end
      r.scl       = bus_scl;
      r.sda_level = bus_sda;
      r.sda_drive = bus_drv;
      r.busy      = (bus_kind != KIND_NONE);
      r.read_data = bus_shift;
      r.nack      = bus_nack;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
      $display("%0t ns: rsp transfer %0d, %s is %0h, expected %0h",
               $time, rsp_count, field, got, want);
      error_count++;
   endtask

   task automatic check_pins(pin_result_type got);
      pin_result_type want;
      want = expected_pins.pop_front();
      if (got.scl !== want.scl) report_mismatch("scl", 8'(got.scl), 8'(want.scl));
      if (got.sda_level !== want.sda_level)
         report_mismatch("sda_level", 8'(got.sda_level), 8'(want.sda_level));
      if (got.sda_drive !== want.sda_drive)
         report_mismatch("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
      if (got.busy !== want.busy) report_mismatch("busy", 8'(got.busy), 8'(want.busy));
      if (got.done !== want.done) report_mismatch("done", 8'(got.done), 8'(want.done));
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.nack !== want.nack) report_mismatch("nack", 8'(got.nack), 8'(want.nack));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pins.size() == 0) report_mismatch("unexpected transfer", 8'd0, 8'd0);
         else check_pins(pin_result_type'(rsp_tdata[13:0]));
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("sccb_register_access_master_unit regression: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, plus long holds requested through sink_hold
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (sink_hold > 0) begin
            rsp_tready <= 1'b0;
            sink_hold--;
         end else if (!sink_idle_on) begin
            rsp_tready <= 1'b1;
         end else begin
            gap = pick_gap();
            rsp_tready <= (gap == 0);
            if (gap > 0) sink_hold = gap - 1;
         end
      end
   end

   task automatic send_item(logic [1:0] op, logic [7:0] ra, logic [7:0] wd, logic sda);
      int gap;
      gap = src_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, sda, wd, ra};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      expected_pins.push_back(predict_pin_step(op, ra, wd, sda));
      items_sent++;
   endtask

   function automatic logic pick_sda(sda_mode_type mode);
      case (mode)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom);
      endcase
   endfunction

   // stray transfers that a busy unit must ignore
   task automatic send_busy_noise();
      logic [1:0] op;
      case ($urandom_range(0, 2))
         0:       op = OP_WRITE;
         1:       op = OP_READ;
         default: op = OP_UNUSED;
      endcase
      send_item(op, 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic send_ticks(int n, sda_mode_type mode, int noise_pct);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < noise_pct) send_busy_noise();
         send_item(OP_TICK, 8'($urandom), 8'($urandom), pick_sda(mode));
      end
   endtask

   task automatic run_transaction(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
                                  sda_mode_type mode, int noise_pct);
      send_item(op, ra, wd, 1'($urandom));
      send_ticks((op == OP_READ) ? READ_TICKS : WRITE_TICKS, mode, noise_pct);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_read_check();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_DEVICE_ADDRESS;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[6:0] !== bus_dev_addr)
         report_mismatch("device_address readback", {1'b0, csr_prdata[6:0]},
                         {1'b0, bus_dev_addr});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_device_address(logic [6:0] addr);
      logic [31:0] value;
      wait_for_drain();
      value = $urandom;
      value[6:0] = addr;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_DEVICE_ADDRESS;
      csr_pwdata  <= value;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      bus_dev_addr = addr;
      @(posedge clock);
      csr_read_check();
   endtask

   task automatic test_idle_inputs();
      send_item(OP_TICK, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);
      send_item(OP_UNUSED, 8'h00, 8'h00, 1'b0);
      send_item(OP_TICK, 8'h00, 8'h00, 1'b0);
   endtask

   task automatic test_device_address_reset();
      wait_for_drain();
      csr_read_check();
   endtask

   // all-ones address, acks high; commands and unused codes arrive mid-write
   task automatic test_write_extremes();
      set_device_address(7'h7F);
      send_item(OP_WRITE, 8'hFF, 8'h00, 1'b0);
      send_ticks(5, SDA_HIGH, 0);
      send_item(OP_READ, 8'h5A, 8'hA5, 1'b1);
      send_item(OP_UNUSED, 8'h00, 8'hFF, 1'b0);
      send_item(OP_WRITE, 8'h00, 8'hFF, 1'b1);
      send_ticks(WRITE_TICKS - 5, SDA_HIGH, 0);
      send_item(OP_TICK, 8'h00, 8'h00, 1'b1);
   endtask

   task automatic test_read_extremes();
      set_device_address(7'h00);
      run_transaction(OP_READ, 8'h00, 8'hFF, SDA_HIGH, 0);
      run_transaction(OP_READ, 8'hFF, 8'h00, SDA_LOW, 0);
   endtask

   task automatic test_back_pressure();
      wait_for_drain();
      src_idle_on = 1'b0;
      sink_hold = 300;
      run_transaction(OP_READ, 8'($urandom), 8'($urandom), SDA_RANDOM, 0);
      wait_for_drain();
      src_idle_on = 1'b1;
   endtask

   task automatic test_random();
      logic [1:0] op;
      logic [6:0] addr;
      int n;
      while (items_sent < ITEM_TARGET) begin
         src_idle_on  = ($urandom_range(0, 3) != 0);
         sink_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0:       addr = 7'h00;
               1:       addr = 7'h7F;
               2:       addr = DEVICE_ADDR_RESET;
               default: addr = 7'($urandom);
            endcase
            set_device_address(addr);
         end
         op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
         run_transaction(op, 8'($urandom), 8'($urandom),
                         sda_mode_type'($urandom_range(0, 2)), 4);
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         for (int k = 0; k < n; k++)
            send_item($urandom_range(0, 1) ? OP_TICK : OP_UNUSED, 8'($urandom),
                      8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_inputs();
      test_device_address_reset();
      test_write_extremes();
      test_read_extremes();
      test_back_pressure();
      test_random();
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("sccb_register_access_master_unit regression: pass");
      end else begin
         $display("sccb_register_access_master_unit regression: fail");
      end
      $finish;
   end

endmodule
